// ----- rtl/core/sdh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdh_pkg
// shared types and constants of the squared distance histogram block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdh_pkg;

  localparam int SDH_NUM_BINS   = 32;
  localparam int SDH_COUNT_BITS = 24;

  localparam int DIST_W  = 24;
  localparam int MSD_W   = 32;
  localparam int SQ_W    = 48;
  localparam int SUM_W   = 56;
  localparam int SQSUM_W = 64;
  localparam int VAL_W   = 48;
  localparam int BIN_W   = 6;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 32;
  localparam int FRAC_W  = 16;

  typedef enum logic [1:0] {
    KIND_MEAN = 2'd0,
    KIND_VAR  = 2'd1,
    KIND_FRAC = 2'd2
  } sdh_kind_t;

  typedef enum logic {
    REG_BIN_WIDTH = 1'b0,
    REG_BINS_USED = 1'b1
  } sdh_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last_sample;
  } sdh_in_t;

  typedef struct packed {
    sdh_kind_t        kind;
    logic [BIN_W-1:0] bin_number;
    logic [VAL_W-1:0] value;
    logic             last_result;
  } sdh_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ1, S_SQ2, S_SRCH, S_RD, S_WR,
    S_M_GO, S_M_WAIT, S_M_OUT,
    S_E_GO, S_E_WAIT, S_V_MUL, S_V_OUT,
    S_B_RD, S_B_GO, S_B_WAIT, S_B_OUT,
    S_CLR
  } sdh_state_t;

  typedef struct packed {
    logic ld;
    logic sq1;
    logic sq2;
    logic srch;
    logic acc_rd;
    logic acc_wr;
    logic ro_rd;
    logic clr;
  } sdh_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sdh_div.sv -----
// ----------------------------------------------------------------------------
// sdh_div
// restoring divider, 64 by 32 bits, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdh_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sdh_pkg::DVD_W-1:0] dividend,
  input  wire logic [sdh_pkg::DVS_W-1:0] divisor,
  output logic      [sdh_pkg::DVD_W-1:0] quotient,
  output logic                           done
);
  import sdh_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W:0]    sh;
  logic              ge;

  assign sh = {rem_r, quo_r[DVD_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? DVS_W'(sh - {1'b0, dvs_r}) : sh[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start && !busy_r) dvs_r <= divisor;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- rtl/core/sdh_acc.sv -----
// ----------------------------------------------------------------------------
// sdh_acc
// squaring, bin search, sums and the bin count memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdh_acc #(
  parameter int NUM_BINS   = sdh_pkg::SDH_NUM_BINS,
  parameter int COUNT_BITS = sdh_pkg::SDH_COUNT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sdh_pkg::sdh_ctl_t           ctl,
  input  wire logic [sdh_pkg::DIST_W-1:0]  distance,
  input  wire logic [sdh_pkg::MSD_W-1:0]   bin_width,
  input  wire logic [sdh_pkg::BIN_W-1:0]   lim,
  input  wire logic [sdh_pkg::BIN_W-1:0]   ro_bin,
  output logic      [sdh_pkg::SUM_W-1:0]   msd_sum,
  output logic      [sdh_pkg::SQSUM_W-1:0] sq_sum,
  output logic      [COUNT_BITS-1:0]       count,
  output logic      [COUNT_BITS-1:0]       bin_data,
  output logic                             srch_last
);
  import sdh_pkg::*;

  localparam int DEPTH = NUM_BINS + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [DIST_W-1:0]     d_r;
  logic [MSD_W-1:0]      msd_r;
  logic [SQ_W-1:0]       sq_r;
  logic [BIN_W-1:0]      cur_r;
  logic [2:0]            bit_r;
  logic [BIN_W-1:0]      trial;
  logic [BIN_W+MSD_W-1:0] prod;
  logic                  fits;
  logic [SUM_W-1:0]      sum_r;
  logic [SQSUM_W-1:0]    sqs_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [SUM_W:0]        sum_add;
  logic [SQSUM_W:0]      sqs_add;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  vq_r;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [2*DIST_W-1:0]   dsq;
  logic [2*MSD_W-1:0]    msq;

  assign trial   = cur_r | (BIN_W'(1) << bit_r);
  assign prod    = trial * bin_width;
  assign fits    = (trial <= lim) && (prod <= {{BIN_W{1'b0}}, msd_r});
  assign dsq     = d_r * d_r;
  assign msq     = msd_r * msd_r;
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(msd_r);
  assign sqs_add = {1'b0, sqs_r} + (SQSUM_W + 1)'(sq_r);
  assign raddr   = ctl.acc_rd ? cur_r[AW-1:0] : ro_bin[AW-1:0];
  assign waddr   = cur_r[AW-1:0];
  assign bin_data = vq_r ? mem_q_r : '0;
  assign wdata   = (bin_data == '1) ? bin_data : bin_data + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.ld)  d_r   <= distance;
    if (ctl.sq1) msd_r <= dsq[2*DIST_W-1:FRAC_W];
    if (ctl.sq2) sq_r  <= msq[2*MSD_W-1:FRAC_W];
    if (ctl.sq2) begin
      cur_r <= '0;
      bit_r <= 3'(BIN_W - 1);
    end else if (ctl.srch) begin
      if (fits) cur_r <= trial;
      bit_r <= bit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      sum_r <= '0;
      sqs_r <= '0;
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      if (ctl.acc_rd) begin
        sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        sqs_r <= sqs_add[SQSUM_W] ? '1 : sqs_add[SQSUM_W-1:0];
        if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.acc_wr) vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_wr) mem[waddr] <= wdata;
    if (ctl.acc_rd || ctl.ro_rd) begin
      mem_q_r <= mem[raddr];
      vq_r    <= vld_r[raddr];
    end
  end

  assign msd_sum   = sum_r;
  assign sq_sum    = sqs_r;
  assign count     = cnt_r;
  assign srch_last = (bit_r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/squared_distance_histogram_stats.sv -----
// ----------------------------------------------------------------------------
// squared_distance_histogram_stats
// histogram of squared distances with running mean and variance
// ----------------------------------------------------------------------------
// in_valid/in_stall carry one distance word per sample; out_valid/out_stall
// carry result words; psel/penable/pwrite/paddr/pwdata set bin_width
// (address 0) and bins_used (address 4).
// After acceptance a sample is squared, squared again, passes six steps of
// the bin search, a read and a write-back of the bin count memory, and
// returns to the idle state that takes the next word; no new word is taken
// before then.
// A word flagged last_sample starts the readout: mean, variance and one
// fraction per bin up to the bin limit. Each result needs one pass of the
// shared divider. No sample is taken during the readout. A stalled result
// holds in the output register and the readout waits for it.
// After the last result the sums, the count and the bin store clear together
// in the clear state, the bin store through per-entry valid bits. Reset clears
// the same state and loads bin_width 1.0 and bins_used 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module squared_distance_histogram_stats #(
  parameter int NUM_BINS   = sdh_pkg::SDH_NUM_BINS,
  parameter int COUNT_BITS = sdh_pkg::SDH_COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sdh_pkg::sdh_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sdh_pkg::sdh_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import sdh_pkg::*;

  sdh_state_t state_r, state_nxt;
  sdh_ctl_t   ctl;

  logic [MSD_W-1:0]      bin_width_r;
  logic [BIN_W-1:0]      bins_used_r;
  logic [BIN_W-1:0]      lim;
  logic                  last_r;
  logic [BIN_W-1:0]      bin_r;
  logic [VAL_W-1:0]      mean_r;
  logic [SQSUM_W-1:0]    ex2_r;
  logic [SQSUM_W-1:0]    msq_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [SUM_W-1:0]      msd_sum;
  logic [SQSUM_W-1:0]    sq_sum;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] bin_data;
  logic                  srch_last;
  logic                  cnt0;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [DVD_W-1:0]      div_q;
  logic                  div_done;
  logic                  room;
  logic                  out_load;
  sdh_out_t              emit;
  sdh_out_t              out_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [SQSUM_W-1:0]    var_full;
  logic [VAL_W-1:0]      var_val;
  logic [2*MSD_W-1:0]    mean_sq;
  logic                  wr_en;
  sdh_reg_t              wr_idx;

  assign lim     = (bins_used_r > BIN_W'(NUM_BINS)) ? BIN_W'(NUM_BINS) : bins_used_r;
  assign cnt0    = (count == '0);
  assign room    = !out_valid_r || !out_stall;
  assign mean_sq = mean_r[MSD_W-1:0] * mean_r[MSD_W-1:0];
  assign var_full = (ex2_r > msq_r) ? ex2_r - msq_r : '0;
  assign var_val = (var_full[SQSUM_W-1:VAL_W] != '0) ? '1 : var_full[VAL_W-1:0];

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = sdh_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r <= 32'h0001_0000;
      bins_used_r <= BIN_W'(32);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_BIN_WIDTH: bin_width_r <= pwdata;
        REG_BINS_USED: bins_used_r <= pwdata[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_BIN_WIDTH: prdata = bin_width_r;
      REG_BINS_USED: prdata = {{(32 - BIN_W){1'b0}}, bins_used_r};
      default:       prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SQ1;
      S_SQ1:    state_nxt = S_SQ2;
      S_SQ2:    state_nxt = S_SRCH;
      S_SRCH:   if (srch_last) state_nxt = S_RD;
      S_RD:     state_nxt = S_WR;
      S_WR:     state_nxt = last_r ? S_M_GO : S_IDLE;
      S_M_GO:   state_nxt = S_M_WAIT;
      S_M_WAIT: if (div_done) state_nxt = S_M_OUT;
      S_M_OUT:  if (room) state_nxt = S_E_GO;
      S_E_GO:   state_nxt = S_E_WAIT;
      S_E_WAIT: if (div_done) state_nxt = S_V_MUL;
      S_V_MUL:  state_nxt = S_V_OUT;
      S_V_OUT:  if (room) state_nxt = S_B_RD;
      S_B_RD:   state_nxt = S_B_GO;
      S_B_GO:   state_nxt = S_B_WAIT;
      S_B_WAIT: if (div_done) state_nxt = S_B_OUT;
      S_B_OUT:  if (room) state_nxt = (bin_r == lim) ? S_CLR : S_B_RD;
      S_CLR:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    div_start = 1'b0;
    div_dvd   = '0;
    out_load  = 1'b0;
    emit      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.ld   = in_valid;
      end
      S_SQ1:  ctl.sq1 = 1'b1;
      S_SQ2:  ctl.sq2 = 1'b1;
      S_SRCH: ctl.srch = 1'b1;
      S_RD:   ctl.acc_rd = 1'b1;
      S_WR:   ctl.acc_wr = 1'b1;
      S_M_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(msd_sum);
      end
      S_M_OUT: begin
        out_load   = room;
        emit.kind  = KIND_MEAN;
        emit.value = mean_r;
      end
      S_E_GO: begin
        div_start = 1'b1;
        div_dvd   = sq_sum;
      end
      S_V_OUT: begin
        out_load   = room;
        emit.kind  = KIND_VAR;
        emit.value = var_val;
      end
      S_B_RD: ctl.ro_rd = 1'b1;
      S_B_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({bin_data, {FRAC_W{1'b0}}});
      end
      S_B_OUT: begin
        out_load         = room;
        emit.kind        = KIND_FRAC;
        emit.bin_number  = bin_r;
        emit.value       = VAL_W'(frac_r);
        emit.last_result = (bin_r == lim);
      end
      S_CLR:  ctl.clr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) last_r <= in_data.last_sample;
    if (state_r == S_M_WAIT && div_done)
      mean_r <= cnt0 ? '0 : ((div_q[DVD_W-1:VAL_W] != '0) ? '1 : div_q[VAL_W-1:0]);
    if (state_r == S_E_WAIT && div_done)
      ex2_r <= cnt0 ? '0 : div_q;
    if (state_r == S_V_MUL)
      msq_r <= (mean_r[VAL_W-1:MSD_W] != '0) ? '1 : SQSUM_W'(mean_sq >> FRAC_W);
    if (state_r == S_B_WAIT && div_done)
      frac_r <= cnt0 ? '0 : ((div_q[DVD_W-1:FRAC_W] != '0) ? '1 : div_q[FRAC_W-1:0]);
    if (state_r == S_V_OUT)
      bin_r <= '0;
    else if (state_r == S_B_OUT && room)
      bin_r <= bin_r + 1'b1;
  end

  // output register
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (out_load) out_r <= emit;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sdh_acc #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .distance  (in_data.distance),
    .bin_width (bin_width_r),
    .lim       (lim),
    .ro_bin    (bin_r),
    .msd_sum   (msd_sum),
    .sq_sum    (sq_sum),
    .count     (count),
    .bin_data  (bin_data),
    .srch_last (srch_last)
  );

  sdh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (DVS_W'(count)),
    .quotient (div_q),
    .done     (div_done)
  );

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_M_WAIT || state_r == S_E_WAIT || state_r == S_B_WAIT))
    else $error("divider result outside a wait state");

  a_last_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit.last_result) |=> (state_r == S_CLR))
    else $error("final result not followed by clear");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (count == '0 && msd_sum == '0 && sq_sum == '0))
    else $error("state not empty after clear");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for squared_distance_histogram_stats
// ----------------------------------------------------------------------------
// Samples are streamed through the input channel while a local predictor
// keeps its own sums, count and histogram. It queues the mean, variance and
// bin fraction words that each flagged sample should produce. A checker
// compares every output word with the oldest queued word, field by field.
// bin_width and bins_used are written and read back only while the block
// is idle. Tests cover the directed extremes, random traffic under several
// settings, and a long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import sdh_pkg::*;

  localparam int  LIMIT     = 4000000;
  localparam int  SETTLE    = 24;
  localparam logic [63:0] CNT_MAX = (64'd1 << SDH_COUNT_BITS) - 1;
  localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] VAL_MAX = (64'd1 << VAL_W) - 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sdh_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sdh_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  squared_distance_histogram_stats dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] cur_bin_width = 32'd65536;
  logic [5:0]  cur_bins_used = 6'd32;
  logic [63:0] hist_bins [0:SDH_NUM_BINS];
  logic [63:0] sum_msd, sum_sq, n_samples;
  sdh_out_t    pending_results [$];

  bit  gaps_on = 1'b1;
  int  hold_left = 0;
  int  cycles = 0;
  int  errors = 0;

  function automatic logic [63:0] bin_limit();
    return (cur_bins_used > SDH_NUM_BINS) ? SDH_NUM_BINS : cur_bins_used;
  endfunction

  function automatic void clear_stats();
    for (int b = 0; b <= SDH_NUM_BINS; b++) hist_bins[b] = '0;
    sum_msd = '0;
    sum_sq = '0;
    n_samples = '0;
  endfunction

  function automatic sdh_out_t make_word(sdh_kind_t k, logic [63:0] b,
                                         logic [63:0] v, logic l);
    sdh_out_t w;
    w.kind = k;
    w.bin_number = b[BIN_W-1:0];
    w.value = v[VAL_W-1:0];
    w.last_result = l;
    return w;
  endfunction

  function automatic void predict_sample(sdh_in_t w);
    logic [63:0] d, msd, sq, idx, lim, mean, var_v, ex2, msq, frac;
    d = 64'(w.distance);
    lim = bin_limit();
    msd = (d * d) >> 16;
    if (msd > 64'hFFFF_FFFF) msd = 64'hFFFF_FFFF;
    sq = (msd * msd) >> 16;
    sum_msd = (SUM_MAX - sum_msd < msd) ? SUM_MAX : sum_msd + msd;
    sum_sq = ('1 - sum_sq < sq) ? '1 : sum_sq + sq;
    if (n_samples < CNT_MAX) n_samples++;
    idx = (cur_bin_width == 0) ? lim : msd / 64'(cur_bin_width);
    if (idx > lim) idx = lim;
    if (hist_bins[idx] < CNT_MAX) hist_bins[idx]++;
    if (!w.last_sample) return;
    mean = '0;
    var_v = '0;
    if (n_samples != 0) begin
      mean = sum_msd / n_samples;
      if (mean > VAL_MAX) mean = VAL_MAX;
      ex2 = sum_sq / n_samples;
      msq = (mean > 64'hFFFF_FFFF) ? '1 : (mean * mean) >> 16;
      var_v = (ex2 > msq) ? ex2 - msq : '0;
      if (var_v > VAL_MAX) var_v = VAL_MAX;
    end
    pending_results.push_back(make_word(KIND_MEAN, 0, mean, 1'b0));
    pending_results.push_back(make_word(KIND_VAR, 0, var_v, 1'b0));
    for (logic [63:0] b = 0; b <= lim; b++) begin
      frac = '0;
      if (n_samples != 0) begin
        frac = (hist_bins[b] << 16) / n_samples;
        if (frac > 64'hFFFF) frac = 64'hFFFF;
      end
      pending_results.push_back(make_word(KIND_FRAC, b, frac, b == lim));
    end
    clear_stats();
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, out_data);
        errors++;
      end else begin
        sdh_out_t exp_w;
        exp_w = pending_results.pop_front();
        if (exp_w.kind != out_data.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, out_data.kind);
          errors++;
        end
        if (exp_w.bin_number != out_data.bin_number) begin
          $display("%0t: bin_number expected %0d actual %0d", $time,
                   exp_w.bin_number, out_data.bin_number);
          errors++;
        end
        if (exp_w.value != out_data.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_w.value, out_data.value);
          errors++;
        end
        if (exp_w.last_result != out_data.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time,
                   exp_w.last_result, out_data.last_result);
          errors++;
        end
      end
    end
  end

  // receiver stall, with a counted long hold
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(logic [23:0] sample_d, logic last);
    sdh_in_t w;
    w.distance = sample_d;
    w.last_sample = last;
    if (gaps_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    predict_sample(w);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(sdh_reg_t idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_BIN_WIDTH) ? 32'hFFFF_FFFF : 32'h3F;
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk) penable <= 1'b1;
    @(posedge clk) begin psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; end
    @(posedge clk) penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) != (val & mask)) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, val & mask,
               prdata & mask);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_BIN_WIDTH) cur_bin_width = val;
    else cur_bins_used = val[5:0];
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_dist();
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      default: return 24'($urandom_range(0, 24'h6_0000));
    endcase
  endfunction

  task automatic test_directed();
    send_word(24'h0, 1'b1);
    send_word(24'hFFFFFF, 1'b1);
    send_word(24'h010000, 1'b0);
    send_word(24'h000001, 1'b0);
    send_word(24'h5A5A5A, 1'b0);
    send_word(24'hA5A5A5, 1'b0);
    send_word(24'h018000, 1'b1);
    wait_idle();
    cfg_write(REG_BIN_WIDTH, 32'h0);
    cfg_write(REG_BINS_USED, 32'd0);
    send_word(24'h020000, 1'b0);
    send_word(24'h000000, 1'b1);
    wait_idle();
    cfg_write(REG_BIN_WIDTH, 32'hFFFF_FFFF);
    cfg_write(REG_BINS_USED, 32'd63);
    send_word(24'hFFFFFF, 1'b0);
    send_word(24'h7FFFFF, 1'b1);
    wait_idle();
    cfg_write(REG_BIN_WIDTH, 32'd1);
    cfg_write(REG_BINS_USED, 32'd1);
    send_word(24'h000001, 1'b0);
    send_word(24'h000100, 1'b0);
    send_word(24'h800000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] widths [4] = '{32'h1_0000, 32'h0_4000, 32'h3_0000, 32'h0};
    for (int phase = 0; phase < 6; phase++) begin
      cfg_write(REG_BIN_WIDTH, (phase == 5) ? 32'($urandom) : widths[phase % 4]);
      cfg_write(REG_BINS_USED, $urandom_range(0, 40));
      gaps_on = (phase != 1);
      for (int i = 0; i < 45; i++) send_word(rand_dist(), $urandom_range(24) == 0);
      send_word(rand_dist(), 1'b1);
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    cfg_write(REG_BIN_WIDTH, 32'h1_0000);
    cfg_write(REG_BINS_USED, 32'd32);
    hold_left = 3000;
    for (int i = 0; i < 8; i++) send_word(rand_dist(), 1'b0);
    send_word(rand_dist(), 1'b1);
    for (int i = 0; i < 6; i++) send_word(rand_dist(), 1'b0);
    send_word(rand_dist(), 1'b1);
    wait_idle();
  endtask

  initial begin
    clear_stats();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
